// ===== rtl/core/stsi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stsi_pkg
// Types, constants and character helpers for the string to integer converter.
// ----------------------------------------------------------------------------
package stsi_pkg;

  localparam int INDEX_WIDTH = 16;
  localparam int MAG_WIDTH   = 64;
  localparam int PROD_WIDTH  = MAG_WIDTH + 6;
  localparam int END_WIDTH   = 16;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [1:0] STATUS_NO_DIGIT = 2'd2;
  localparam logic [1:0] STATUS_BAD_BASE = 2'd3;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [5:0] BASE_HEX = 6'd16;
  localparam logic [5:0] BASE_OCT = 6'd8;
  localparam logic [5:0] BASE_DEC = 6'd10;
  localparam logic [5:0] BASE_MAX = 6'd36;
  localparam logic [5:0] NOT_DIGIT = 6'd63;

  typedef struct packed {
    logic [7:0] char_in;
    logic       start_req;
    logic [5:0] radix;
  } stsi_in_t;

  typedef struct packed {
    logic signed [MAG_WIDTH-1:0] result_value;
    logic [END_WIDTH-1:0]        end_index;
    logic [1:0]                  status;
  } stsi_out_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // digit value, or a code no base reaches
  function automatic logic [5:0] digit_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
      v = c - CH_ZERO;
    end else if ((c >= CH_LO_A) && (c <= CH_LO_Z)) begin
      v = c - CH_LO_A + 8'd10;
    end else if ((c >= CH_UP_A) && (c <= CH_UP_Z)) begin
      v = c - CH_UP_A + 8'd10;
    end else begin
      v = {2'b00, NOT_DIGIT};
    end
    return v[5:0];
  endfunction

  function automatic logic [INDEX_WIDTH-1:0] pos_inc(input logic [INDEX_WIDTH-1:0] p);
    return (p == {INDEX_WIDTH{1'b1}}) ? p : p + 1'b1;
  endfunction

  function automatic logic [END_WIDTH-1:0] sat_end(input logic [INDEX_WIDTH-1:0] p);
    logic [31:0] wide;
    wide = 32'(p);
    return (wide > 32'h0000_FFFF) ? {END_WIDTH{1'b1}} : wide[END_WIDTH-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/stsi_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stsi_parser
// Parse state register and the per-byte step: blanks, sign, prefix, digits.
// ----------------------------------------------------------------------------
module stsi_parser (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire stsi_pkg::stsi_in_t item_i,
  output logic                    push_o,
  output stsi_pkg::stsi_out_t     result_o
);
  import stsi_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_PREFIX,
    PH_DIGITS
  } phase_e;

  typedef struct packed {
    phase_e                 phase;
    logic                   negative;
    logic [5:0]             base;
    logic [MAG_WIDTH-1:0]   mag;
    logic [INDEX_WIDTH-1:0] pos;
    logic                   any_digit;
    logic                   ovf;
    logic [INDEX_WIDTH-1:0] fb_end;
  } pstate_t;

  localparam pstate_t PST_RESET = '{
    phase: PH_IDLE, negative: 1'b0, base: '0, mag: '0,
    pos: '0, any_digit: 1'b0, ovf: 1'b0, fb_end: '0
  };

  localparam logic [MAG_WIDTH-1:0] POS_LIMIT = {1'b0, {(MAG_WIDTH-1){1'b1}}};
  localparam logic [MAG_WIDTH-1:0] NEG_LIMIT = {1'b1, {(MAG_WIDTH-1){1'b0}}};

  pstate_t state_q, state_d;
  pstate_t s, n;
  logic [5:0] digit, td_base;
  logic [MAG_WIDTH-1:0] limit;
  logic [PROD_WIDTH-1:0] prod;
  logic bad_base, lead_zero, take, fin, push;
  stsi_out_t res;

  always_comb begin
    s = state_q;
    if (item_i.start_req) begin
      s = PST_RESET;
      s.base = item_i.radix;
      s.phase = PH_SPACE;
    end
  end

  // effective base of a digit taken in this phase
  always_comb begin
    case (s.phase)
      PH_SPACE, PH_SIGNED: td_base = (s.base == 6'd0) ? BASE_DEC : s.base;
      PH_ZERO:             td_base = (s.base == 6'd0) ? BASE_OCT : s.base;
      PH_PREFIX:           td_base = BASE_HEX;
      default:             td_base = s.base;
    endcase
  end

  assign digit = digit_of(item_i.char_in);
  assign limit = s.negative ? NEG_LIMIT : POS_LIMIT;
  // m*b + d > limit is the same test as m > (limit - d) / b
  assign prod  = PROD_WIDTH'(s.mag) * PROD_WIDTH'(td_base) + PROD_WIDTH'(digit);

  assign bad_base  = item_i.start_req &&
                     ((item_i.radix == 6'd1) || (item_i.radix > BASE_MAX));
  assign lead_zero = (item_i.char_in == CH_ZERO) &&
                     ((s.base == 6'd0) || (s.base == BASE_HEX));

  always_comb begin
    n    = s;
    take = 1'b0;
    fin  = 1'b0;
    push = 1'b0;
    res  = '0;
    if (bad_base) begin
      push       = 1'b1;
      res.status = STATUS_BAD_BASE;
      n.phase    = PH_IDLE;
    end else begin
      case (s.phase)
        PH_SPACE: begin
          if (is_blank(item_i.char_in)) begin
            n.pos = pos_inc(s.pos);
          end else if ((item_i.char_in == CH_MINUS) || (item_i.char_in == CH_PLUS)) begin
            n.negative = (item_i.char_in == CH_MINUS);
            n.phase    = PH_SIGNED;
            n.pos      = pos_inc(s.pos);
          end else if (lead_zero) begin
            n.any_digit = 1'b1;
            n.fb_end    = pos_inc(s.pos);
            n.phase     = PH_ZERO;
            n.pos       = pos_inc(s.pos);
          end else begin
            take = 1'b1;
          end
        end
        PH_SIGNED: begin
          if (lead_zero) begin
            n.any_digit = 1'b1;
            n.fb_end    = pos_inc(s.pos);
            n.phase     = PH_ZERO;
            n.pos       = pos_inc(s.pos);
          end else begin
            take = 1'b1;
          end
        end
        PH_ZERO: begin
          if ((item_i.char_in == CH_LO_X) || (item_i.char_in == CH_UP_X)) begin
            n.phase = PH_PREFIX;
            n.pos   = pos_inc(s.pos);
          end else begin
            take = 1'b1;
          end
        end
        PH_PREFIX: take = 1'b1;
        PH_DIGITS: take = 1'b1;
        PH_IDLE:   ;
        default:   ;
      endcase

      if (take) begin
        n.base = td_base;
        if ((digit >= td_base) || (td_base < 6'd2)) begin
          fin = 1'b1;
        end else begin
          if (!s.ovf) begin
            if (prod > PROD_WIDTH'(limit)) begin
              n.ovf = 1'b1;
              n.mag = limit;
            end else begin
              n.mag = prod[MAG_WIDTH-1:0];
            end
          end
          n.any_digit = 1'b1;
          n.fb_end    = pos_inc(s.pos);
          n.phase     = PH_DIGITS;
          n.pos       = pos_inc(s.pos);
        end
      end

      if (fin) begin
        push    = 1'b1;
        n.phase = PH_IDLE;
        if (s.ovf) begin
          res.result_value = limit;
          res.end_index    = sat_end(s.fb_end);
          res.status       = STATUS_OVERFLOW;
        end else if (!s.any_digit) begin
          res.status = STATUS_NO_DIGIT;
        end else begin
          res.result_value = s.negative ? MAG_WIDTH'(0) - s.mag : s.mag;
          res.end_index    = sat_end(s.fb_end);
          res.status       = STATUS_OK;
        end
      end
    end
  end

  assign state_d  = accept_i ? n : state_q;
  assign push_o   = accept_i && push;
  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PST_RESET;
    end else begin
      state_q <= state_d;
    end
  end

  // a bad base answers on the start byte itself
  a_bad_base_now: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && bad_base) |-> (push_o && (result_o.status == STATUS_BAD_BASE)))
    else $error("bad base item gave no result");

  // the accumulator never exceeds the limit of its sign
  a_mag_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_DIGITS) |->
      (state_q.mag <= (state_q.negative ? NEG_LIMIT : POS_LIMIT)))
    else $error("accumulator above signed limit");

endmodule
`default_nettype wire

// ===== rtl/core/stsi_out_buf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stsi_out_buf
// Two-entry result buffer: an output register backed by a skid register.
// ----------------------------------------------------------------------------
module stsi_out_buf (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire stsi_pkg::stsi_out_t push_data_i,
  output logic                     push_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output stsi_pkg::stsi_out_t      out_data_o
);
  import stsi_pkg::*;

  logic      main_valid_q, main_valid_d;
  logic      skid_valid_q, skid_valid_d;
  stsi_out_t main_q, main_d;
  stsi_out_t skid_q, skid_d;
  logic      pop;

  assign pop = main_valid_q && out_ready_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_d       = push_data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign push_ready_o = !skid_valid_q;
  assign out_valid_o  = main_valid_q;
  assign out_data_o   = main_q;

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry without output entry");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("result pushed into full buffer");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_ready_i) |=> (main_valid_q && !skid_valid_q))
    else $error("skid entry not moved up after pop");

endmodule
`default_nettype wire

// ===== rtl/core/string_to_signed_integer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// string_to_signed_integer
// Byte-stream strtoll-style converter with saturation, end index and status.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the result buffer's skid entry is free;
//   the accumulator multiply-add and its limit compare sit between the parse state register and the result buffer.
// A result is registered into the two-entry result buffer: its output register,
// or its skid register while a result waits there, which keeps bytes flowing.
// Reset: the parser returns to idle and the result buffer empties.
module string_to_signed_integer (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire stsi_pkg::stsi_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output stsi_pkg::stsi_out_t      out_data_o
);
  import stsi_pkg::*;

  logic      accept;
  logic      push;
  logic      push_ready;
  stsi_out_t result;

  assign in_ready_o = push_ready;
  assign accept     = in_valid_i && push_ready;

  stsi_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .push_o   (push),
    .result_o (result)
  );

  stsi_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (result),
    .push_ready_o (push_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
`default_nettype wire

// ===== tb/stsi_conversion_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stsi_conversion_checker
// Watches both channels of the string to integer converter. Each accepted
// input byte goes through a behavioral parser, which queues the conversion it
// finishes, if any. Every accepted result is compared field by field with the
// oldest queued conversion.
// ----------------------------------------------------------------------------
module stsi_conversion_checker (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_ready_i,
  input  wire stsi_pkg::stsi_in_t  in_data_i,
  input  wire logic                out_valid_i,
  input  wire logic                out_ready_i,
  input  wire stsi_pkg::stsi_out_t out_data_i,
  output int unsigned              mismatch_count_o,
  output int unsigned              pending_o
);
  import stsi_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_SPACE, PH_SIGNED, PH_ZERO, PH_PREFIX, PH_DIGITS
  } parse_phase_e;

  localparam int unsigned  NON_DIGIT = 99;
  localparam logic [63:0]  POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0]  NEG_LIMIT = 64'h8000_0000_0000_0000;

  // parser state
  parse_phase_e        cur_phase;
  logic                is_negative;
  logic [5:0]          active_base;
  logic [63:0]         accum;
  logic [15:0]         char_pos;
  logic                have_digit;
  logic                saturated;
  logic [15:0]         stop_pos;

  stsi_out_t           expected_conversions[$];
  stsi_out_t           want;
  stsi_out_t           conv;

  function automatic logic [15:0] bump_pos(input logic [15:0] p);
    return (p == 16'hFFFF) ? p : p + 16'd1;
  endfunction

  function automatic bit blank_char(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic int unsigned char_value(input logic [7:0] c);
    if ((c >= CH_ZERO) && (c <= CH_NINE)) return int'(c - CH_ZERO);
    if ((c >= CH_LO_A) && (c <= CH_LO_Z)) return 10 + int'(c - CH_LO_A);
    if ((c >= CH_UP_A) && (c <= CH_UP_Z)) return 10 + int'(c - CH_UP_A);
    return NON_DIGIT;
  endfunction

  function automatic void clear_parser();
    cur_phase   = PH_IDLE;
    is_negative = 1'b0;
    active_base = '0;
    accum       = '0;
    char_pos    = '0;
    have_digit  = 1'b0;
    saturated   = 1'b0;
    stop_pos    = '0;
  endfunction

  function automatic stsi_out_t close_conversion();
    stsi_out_t r;
    r = '0;
    if (saturated) begin
      r.result_value = is_negative ? NEG_LIMIT : POS_LIMIT;
      r.end_index    = stop_pos;
      r.status       = STATUS_OVERFLOW;
    end else if (!have_digit) begin
      r.status       = STATUS_NO_DIGIT;
    end else begin
      r.result_value = is_negative ? 64'd0 - accum : accum;
      r.end_index    = stop_pos;
      r.status       = STATUS_OK;
    end
    cur_phase = PH_IDLE;
    return r;
  endfunction

  // take c as a digit of the active base, or close the conversion
  function automatic bit add_digit(input logic [7:0] c, output stsi_out_t r);
    int unsigned d;
    logic [63:0] b;
    logic [63:0] lim;
    r = '0;
    d = char_value(c);
    if ((d >= int'(active_base)) || (active_base < 6'd2)) begin
      r = close_conversion();
      return 1'b1;
    end
    b   = 64'(active_base);
    lim = is_negative ? NEG_LIMIT : POS_LIMIT;
    if (!saturated) begin
      if (accum > (lim - 64'(d)) / b) begin
        saturated = 1'b1;
        accum     = lim;
      end else begin
        accum = accum * b + 64'(d);
      end
    end
    have_digit = 1'b1;
    stop_pos   = bump_pos(char_pos);
    cur_phase  = PH_DIGITS;
    char_pos   = bump_pos(char_pos);
    return 1'b0;
  endfunction

  // first byte after blanks and sign
  function automatic bit lead_char(input logic [7:0] c, output stsi_out_t r);
    r = '0;
    if ((c == CH_ZERO) && ((active_base == 6'd0) || (active_base == BASE_HEX))) begin
      have_digit = 1'b1;
      stop_pos   = bump_pos(char_pos);
      cur_phase  = PH_ZERO;
      char_pos   = bump_pos(char_pos);
      return 1'b0;
    end
    if (active_base == 6'd0) active_base = BASE_DEC;
    return add_digit(c, r);
  endfunction

  function automatic bit convert_byte(input stsi_in_t item, output stsi_out_t r);
    logic [7:0] c;
    r = '0;
    c = item.char_in;
    if (item.start_req) begin
      clear_parser();
      active_base = item.radix;
      if ((active_base == 6'd1) || (active_base > BASE_MAX)) begin
        r.status  = STATUS_BAD_BASE;
        cur_phase = PH_IDLE;
        return 1'b1;
      end
      cur_phase = PH_SPACE;
    end
    case (cur_phase)
      PH_SPACE: begin
        if (blank_char(c)) begin
          char_pos = bump_pos(char_pos);
          return 1'b0;
        end
        if ((c == CH_MINUS) || (c == CH_PLUS)) begin
          is_negative = (c == CH_MINUS);
          cur_phase   = PH_SIGNED;
          char_pos    = bump_pos(char_pos);
          return 1'b0;
        end
        return lead_char(c, r);
      end
      PH_SIGNED: return lead_char(c, r);
      PH_ZERO: begin
        if ((c == CH_LO_X) || (c == CH_UP_X)) begin
          cur_phase = PH_PREFIX;
          char_pos  = bump_pos(char_pos);
          return 1'b0;
        end
        if (active_base == 6'd0) active_base = BASE_OCT;
        return add_digit(c, r);
      end
      PH_PREFIX: begin
        active_base = BASE_HEX;
        return add_digit(c, r);
      end
      PH_DIGITS: return add_digit(c, r);
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      expected_conversions.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      // compare before queueing: no result can stem from this cycle's item
      if (out_valid_i && out_ready_i) begin
        if (expected_conversions.size() == 0) begin
          $display("%0t: result with no conversion pending: value %0d end %0d status %0d",
                   $time, out_data_i.result_value, out_data_i.end_index, out_data_i.status);
          mismatch_count_o++;
        end else begin
          want = expected_conversions.pop_front();
          if ((out_data_i.result_value !== want.result_value) ||
              (out_data_i.end_index !== want.end_index) ||
              (out_data_i.status !== want.status)) begin
            $display({"%0t: mismatch: expected value %0d end %0d status %0d,",
                      " got value %0d end %0d status %0d"},
                     $time, want.result_value, want.end_index, want.status,
                     out_data_i.result_value, out_data_i.end_index, out_data_i.status);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (convert_byte(in_data_i, conv)) expected_conversions.push_back(conv);
      end
      pending_o = expected_conversions.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives strings into the string to integer converter: a directed set of
// corner cases, then random strings and noise under four idling mixes on
// the input and output channels. The checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;
  import stsi_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned PHASE_BYTES   = 500;

  typedef logic [7:0] byte_q_t[$];

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  stsi_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  stsi_out_t   out_data;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned cycle_count = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  string_to_signed_integer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  stsi_conversion_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // valid stays high between back-to-back items; it drops only for a gap
  task automatic send_item(input stsi_in_t item);
    int unsigned gap;
    gap = 0;
    while (($urandom_range(99) < send_idle_pct) && (gap < 30)) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic send_string(input byte_q_t chars, input logic [5:0] rdx);
    stsi_in_t item;
    for (int i = 0; i < chars.size(); i++) begin
      item.char_in   = chars[i];
      item.start_req = (i == 0);
      item.radix     = (i == 0) ? rdx : 6'($urandom_range(63));
      send_item(item);
    end
  endtask

  task automatic send_text(input string s, input logic [5:0] rdx, input bit nul);
    byte_q_t chars;
    for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
    if (nul) chars.push_back(8'h00);
    send_string(chars, rdx);
  endtask

  task automatic send_noise(input bit with_start);
    stsi_in_t item;
    item.char_in   = 8'($urandom_range(255));
    item.start_req = with_start;
    item.radix     = 6'($urandom_range(63));
    send_item(item);
  endtask

  function automatic logic [7:0] digit_char(input int unsigned d, input bit upper);
    if (d < 10) return CH_ZERO + 8'(d);
    return (upper ? CH_UP_A : CH_LO_A) + 8'(d - 10);
  endfunction

  // mostly well-formed strings with random content, some broken ones
  task automatic build_random_string(output byte_q_t chars, output logic [5:0] rdx);
    int unsigned sel;
    int unsigned nd;
    int unsigned b;
    chars = {};
    sel = $urandom_range(99);
    if (sel < 30) rdx = 6'd0;
    else if (sel < 40) rdx = BASE_DEC;
    else if (sel < 44) rdx = $urandom_range(1) ? 6'd1 : 6'($urandom_range(37, 63));
    else rdx = 6'($urandom_range(2, 36));
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        chars.push_back($urandom_range(1) ? CH_SPACE : CH_TAB + 8'($urandom_range(4)));
      end
    end
    case ($urandom_range(2))
      0: chars.push_back(CH_PLUS);
      1: chars.push_back(CH_MINUS);
      default: ;
    endcase
    b = ((rdx == 6'd0) || (rdx == 6'd1) || (rdx > BASE_MAX)) ? 10 : int'(rdx);
    if (((rdx == 6'd0) || (rdx == BASE_HEX)) && ($urandom_range(9) < 4)) begin
      chars.push_back(CH_ZERO);
      if ($urandom_range(9) < 7) begin
        chars.push_back($urandom_range(1) ? CH_LO_X : CH_UP_X);
        b = 16;
      end else if (rdx == 6'd0) begin
        b = 8;
      end
    end
    sel = $urandom_range(99);
    if (sel < 3) nd = $urandom_range(60, 70);
    else if (sel < 18) nd = $urandom_range(15, 25);
    else nd = $urandom_range(0, 8);
    repeat (nd) begin
      if ($urandom_range(99) < 4) chars.push_back(8'($urandom_range(255)));
      else chars.push_back(digit_char($urandom_range(b - 1), 1'($urandom_range(1))));
    end
    sel = $urandom_range(99);
    if (sel < 60) chars.push_back(8'h00);
    else if (sel < 90) chars.push_back(8'($urandom_range(255)));
    if (chars.size() == 0) chars.push_back(8'h00);
  endtask

  task automatic run_directed();
    byte_q_t chars;
    send_text("  -123", BASE_DEC, 1'b1);
    send_text("\011\012\013\014\015+42", 6'd0, 1'b1);
    send_text("0x1F", 6'd0, 1'b1);
    send_text("-0X7fz", BASE_HEX, 1'b1);
    send_text("0x", 6'd0, 1'b1);
    send_text("0xg", BASE_HEX, 1'b1);
    send_text("017", 6'd0, 1'b1);
    send_text("0x1", BASE_OCT, 1'b1);
    send_text("9223372036854775807", BASE_DEC, 1'b1);
    send_text("9223372036854775808", BASE_DEC, 1'b1);
    send_text("-9223372036854775808", BASE_DEC, 1'b1);
    send_text("-9223372036854775809", 6'd0, 1'b1);
    send_text("zZ", BASE_MAX, 1'b1);
    send_text("1012", 6'd2, 1'b1);
    send_text("7", 6'd1, 1'b0);
    send_text("7", 6'd37, 1'b0);
    send_text("7", 6'd63, 1'b0);
    send_text(" +", BASE_DEC, 1'b1);
    send_text("xyz", BASE_DEC, 1'b1);
    send_text("", BASE_DEC, 1'b1);
    // restart abandons the string in progress
    send_text("12", BASE_DEC, 1'b0);
    send_text("34", BASE_DEC, 1'b1);
    // bytes while idle are ignored
    send_noise(1'b0);
    send_noise(1'b0);
    send_text("\377", 6'd35, 1'b0);
    // position keeps counting over a long run of blanks
    repeat (40) chars.push_back(CH_SPACE);
    chars.push_back(CH_ZERO + 8'd7);
    chars.push_back(8'h00);
    send_string(chars, BASE_DEC);
  endtask

  task automatic run_random(input int unsigned byte_budget);
    byte_q_t chars;
    logic [5:0] rdx;
    int unsigned sent;
    sent = 0;
    while (sent < byte_budget) begin
      build_random_string(chars, rdx);
      send_string(chars, rdx);
      sent += chars.size();
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 3)) send_noise(1'b0);
      end
      if ($urandom_range(99) < 3) begin
        send_noise(1'b1);
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned idle_pcts[4];
    int unsigned stall_pcts[4];
    idle_pcts  = '{0, 53, 0, 35};
    stall_pcts = '{0, 0, 53, 35};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_pcts[p];
      recv_stall_pct = stall_pcts[p];
      run_random(PHASE_BYTES);
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if ((mismatch_count == 0) && (pending == 0)) begin
      $display("PASS string_to_signed_integer");
    end else begin
      $display("FAIL string_to_signed_integer");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("FAIL string_to_signed_integer");
    $finish;
  end

endmodule
